// File: rtl/fba_pkg.sv
// Shared constants and codes for the frame bitmap allocator.
`default_nettype none
package fba_pkg;
   localparam int WORD_BITS    = 32;
   localparam int FRAME_W      = 12;
   localparam int CFG_W        = 13;
   localparam int BITPOS_W     = 5;
   localparam int SCAN_W       = 8;
   // Largest scan that keeps every returned index inside the 12-bit frame field.
   localparam int FIELD_WORDS  = 128;
   localparam int FRAME_COUNT_RST = 4096;

   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_NOCHANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [FRAME_W-1:0]   frame_type;
endpackage
`default_nettype wire

// File: rtl/frame_bitmap_allocator_unit.sv
// Top level: first-fit page frame allocator over a bitmap held in RAM.
//
//   channel | ports                                              | dir
//   --------+----------------------------------------------------+-----
//   req     | req_valid, req_stall, mode, current_frame, flags   | in
//   rsp     | rsp_valid, rsp_stall, status, present, rw, user,   | out
//           | frame                                              |
//   csr     | csr_valid, csr_ready, csr_frame_count              | in
//
// Allocate scans the bitmap word by word until a clear bit is found, up to n words
// (n = min(frame_count/32, MAX_FRAMES/32, 128)); the bitmap RAM read port gives one
// word per cycle. Free: read, modify/write, emit. Other requests go straight to emit.
// After reset the bitmap is swept to zero, word by word, with req stalled.
// A finished response may wait in the output register while the next request
// is taken; it only blocks the emit step of the next one.
`default_nettype none
module frame_bitmap_allocator_unit #(
   parameter int MAX_FRAMES = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_mode,
   input  wire logic [11:0] req_current_frame,
   input  wire logic        req_is_kernel,
   input  wire logic        req_is_writeable,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic             rsp_present,
   output logic             rsp_rw,
   output logic             rsp_user,
   output logic [11:0]      rsp_frame,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [12:0] csr_frame_count
);
   localparam int WORDS    = MAX_FRAMES / fba_pkg::WORD_BITS;
   localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int SCAN_CAP = (WORDS < fba_pkg::FIELD_WORDS) ? WORDS : fba_pkg::FIELD_WORDS;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_PICK  = 3'd3;
   localparam logic [2:0] ST_FREE  = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   logic [2:0]                         state_ff, state_in;
   logic [AW-1:0]                      clr_ff, clr_in;
   logic [fba_pkg::CFG_W-1:0]          frame_count_ff, frame_count_in;
   logic [fba_pkg::SCAN_W-1:0]         idx_ff, idx_in;
   fba_pkg::word_type                  word_ff, word_in;
   logic [AW-1:0]                      free_addr_ff, free_addr_in;
   logic [fba_pkg::BITPOS_W-1:0]       free_bit_ff, free_bit_in;
   logic                               kern_ff, kern_in;
   logic                               wr_ff, wr_in;

   logic [1:0]                         res_status_ff, res_status_in;
   logic                               res_present_ff, res_present_in;
   logic                               res_rw_ff, res_rw_in;
   logic                               res_user_ff, res_user_in;
   fba_pkg::frame_type                 res_frame_ff, res_frame_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [1:0]                         rsp_status_ff, rsp_status_in;
   logic                               rsp_present_ff, rsp_present_in;
   logic                               rsp_rw_ff, rsp_rw_in;
   logic                               rsp_user_ff, rsp_user_in;
   fba_pkg::frame_type                 rsp_frame_ff, rsp_frame_in;

   logic                               ram_we;
   logic [AW-1:0]                      ram_waddr;
   fba_pkg::word_type                  ram_wdata;
   logic [AW-1:0]                      ram_raddr;
   fba_pkg::word_type                  ram_rdata;

   logic [fba_pkg::SCAN_W-1:0]         fc_words;
   logic [fba_pkg::SCAN_W-1:0]         scan_n;
   logic [fba_pkg::SCAN_W-1:0]         idx_next;
   logic                               accept;
   logic                               out_free;
   logic                               in_range;
   logic [fba_pkg::BITPOS_W-1:0]       pick_bit;

   fba_ram #(
      .WIDTH (fba_pkg::WORD_BITS),
      .DEPTH (WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign fc_words  = frame_count_ff[fba_pkg::CFG_W-1:fba_pkg::BITPOS_W];
   assign scan_n    = (fc_words > fba_pkg::SCAN_W'(SCAN_CAP)) ?
                      fba_pkg::SCAN_W'(SCAN_CAP) : fc_words;
   assign idx_next  = idx_ff + 1'b1;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign in_range  = {20'd0, req_current_frame} < 32'(MAX_FRAMES);

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // lowest clear bit of the captured word
   always_comb begin
      pick_bit = '0;
      for (int b = fba_pkg::WORD_BITS - 1; b >= 0; b--) begin
         if (!word_ff[b]) begin
            pick_bit = fba_pkg::BITPOS_W'(b);
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      frame_count_in = frame_count_ff;
      idx_in         = idx_ff;
      word_in        = word_ff;
      free_addr_in   = free_addr_ff;
      free_bit_in    = free_bit_ff;
      kern_in        = kern_ff;
      wr_in          = wr_ff;
      res_status_in  = res_status_ff;
      res_present_in = res_present_ff;
      res_rw_in      = res_rw_ff;
      res_user_in    = res_user_ff;
      res_frame_in   = res_frame_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_present_in = rsp_present_ff;
      rsp_rw_in      = rsp_rw_ff;
      rsp_user_in    = rsp_user_ff;
      rsp_frame_in   = rsp_frame_ff;
      ram_we         = 1'b0;
      ram_waddr      = clr_ff;
      ram_wdata      = '0;
      ram_raddr      = AW'(idx_next);

      if (csr_valid && csr_ready) begin
         frame_count_in = csr_frame_count;
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            ram_raddr = (req_mode == fba_pkg::MODE_FREE) ?
                        AW'(req_current_frame[fba_pkg::FRAME_W-1:fba_pkg::BITPOS_W]) : '0;
            if (accept) begin
               kern_in        = req_is_kernel;
               wr_in          = req_is_writeable;
               free_addr_in   = AW'(req_current_frame[fba_pkg::FRAME_W-1:fba_pkg::BITPOS_W]);
               free_bit_in    = req_current_frame[fba_pkg::BITPOS_W-1:0];
               idx_in         = '0;
               res_status_in  = fba_pkg::STATUS_DONE;
               res_present_in = 1'b0;
               res_rw_in      = 1'b0;
               res_user_in    = 1'b0;
               res_frame_in   = '0;
               state_in       = ST_EMIT;
               if (req_mode == fba_pkg::MODE_ALLOC) begin
                  if (req_current_frame != '0) begin
                     res_status_in = fba_pkg::STATUS_NOCHANGE;
                     res_frame_in  = req_current_frame;
                  end else if (scan_n == '0) begin
                     res_status_in = fba_pkg::STATUS_FULL;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else begin
                  if (req_current_frame == '0) begin
                     res_status_in = fba_pkg::STATUS_NOCHANGE;
                  end else if (in_range) begin
                     state_in = ST_FREE;
                  end
               end
            end
         end
         ST_SCAN: begin
            // ram_rdata holds word idx_ff; word idx_ff+1 is already being read
            if (ram_rdata != '1) begin
               word_in  = ram_rdata;
               state_in = ST_PICK;
            end else if (idx_next == scan_n) begin
               res_status_in = fba_pkg::STATUS_FULL;
               state_in      = ST_EMIT;
            end else begin
               idx_in = idx_next;
            end
         end
         ST_PICK: begin
            ram_we         = 1'b1;
            ram_waddr      = AW'(idx_ff);
            ram_wdata      = word_ff | (fba_pkg::word_type'(1) << pick_bit);
            res_status_in  = fba_pkg::STATUS_DONE;
            res_present_in = 1'b1;
            res_rw_in      = wr_ff;
            res_user_in    = !kern_ff;
            res_frame_in   = {idx_ff[fba_pkg::FRAME_W-fba_pkg::BITPOS_W-1:0], pick_bit};
            state_in       = ST_EMIT;
         end
         ST_FREE: begin
            ram_we    = 1'b1;
            ram_waddr = free_addr_ff;
            ram_wdata = ram_rdata & ~(fba_pkg::word_type'(1) << free_bit_ff);
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_present_in = res_present_ff;
               rsp_rw_in      = res_rw_ff;
               rsp_user_in    = res_user_ff;
               rsp_frame_in   = res_frame_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         frame_count_ff <= fba_pkg::CFG_W'(fba_pkg::FRAME_COUNT_RST);
         idx_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         frame_count_ff <= frame_count_in;
         idx_ff         <= idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff        <= word_in;
      free_addr_ff   <= free_addr_in;
      free_bit_ff    <= free_bit_in;
      kern_ff        <= kern_in;
      wr_ff          <= wr_in;
      res_status_ff  <= res_status_in;
      res_present_ff <= res_present_in;
      res_rw_ff      <= res_rw_in;
      res_user_ff    <= res_user_in;
      res_frame_ff   <= res_frame_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_present_ff <= rsp_present_in;
      rsp_rw_ff      <= rsp_rw_in;
      rsp_user_ff    <= rsp_user_in;
      rsp_frame_ff   <= rsp_frame_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_present = rsp_present_ff;
   assign rsp_rw      = rsp_rw_ff;
   assign rsp_user    = rsp_user_ff;
   assign rsp_frame   = rsp_frame_ff;
endmodule
`default_nettype wire

// File: rtl/fba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                                          clock,
   input  wire logic                                          wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]                              wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic      [WIDTH-1:0]                              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
